// File: rtl/core/npcs_pkg.sv
// package: palette search constants, payload structs and state codes
package npcs_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    // field widths
    localparam int CH_W   = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = 20;
    localparam int CFG_W  = 9;

    // channel mask applied before comparing
    localparam logic [CH_W-1:0] CHANNEL_MASK = 8'hfe;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_OFFSET  = 2'd0;
    localparam logic [1:0] CFG_TOTAL_COLORS = 2'd1;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        t_opcode         opcode;
        logic [7:0]      entry_index;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        best_index;
        logic [DIST_W-1:0] best_distance;
    } t_out_item;

    // sequencer controls
    typedef struct packed {
        logic busy;
        logic issue;
    } t_ctrl;

endpackage

// File: rtl/core/nearest_palette_color_search.sv
// top level: palette store with a sequential nearest color search
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ------------------------------
//  command   start, busy, i_in                   transfer when start & !busy
//  result    o_valid, o_out                      one-cycle strobe, no stall
//  config    i_cfg_we, i_cfg_index, i_cfg_data   transfer when i_cfg_we
//
//  a load gives no result
//  a lookup over a window of N entries reads one palette entry per cycle through
//  a single read port and shared distance unit; busy stays high until the result
//  strobe, so the next command can transfer only after a lookup has finished
//  synchronous reset clears control registers and sets the window to the whole palette; the palette is not cleared
//  the receiver cannot stall; results are never held
module nearest_palette_color_search
    import npcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_in,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_out_item        o_out
);

    // palette memory, one 24-bit word per entry
    logic [3*CH_W-1:0] r_palette [PALETTE_DEPTH];

    t_state            r_state, n_state;
    t_ctrl             ctrl;

    logic [7:0]        r_base_offset;
    logic [CFG_W-1:0]  r_total_colors;

    logic [CH_W-1:0]   r_q_red, r_q_green, r_q_blue;
    logic [IDX_W-1:0]  r_rd_addr;
    logic [CNT_W-1:0]  r_left;
    logic              r_first_pend;

    // stage 1: read data
    logic              r_v1, r_first1, r_last1;
    logic [IDX_W-1:0]  r_idx1;
    logic [3*CH_W-1:0] r_rd_data;

    // stage 2: squared channel differences
    logic              r_v2, r_first2, r_last2;
    logic [IDX_W-1:0]  r_idx2;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;

    // running best and result
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              accept;
    logic              load_hit;
    logic [CNT_W-1:0]  base_w;
    logic [CNT_W:0]    end_w;
    logic [CNT_W-1:0]  win_cnt;
    logic [CH_W-1:0]   d_r, d_g, d_b;
    logic [DIST_W-1:0] cand_dist;
    logic              take;
    logic [IDX_W-1:0]  sel_idx;
    logic [DIST_W-1:0] sel_dist;

    assign accept   = start & ~ctrl.busy;
    assign load_hit = ({1'b0, i_in.entry_index} < 9'(PALETTE_DEPTH));

    // window start and length, clipped at the palette end
    always_comb begin
        if ({1'b0, r_base_offset} >= CNT_W'(PALETTE_DEPTH)) begin
            base_w = CNT_W'(PALETTE_DEPTH - 1);
        end else begin
            base_w = CNT_W'(r_base_offset);
        end
        end_w = (CNT_W+1)'(base_w) + (CNT_W+1)'(r_total_colors);
        if (end_w > (CNT_W+1)'(PALETTE_DEPTH)) begin
            end_w = (CNT_W+1)'(PALETTE_DEPTH);
        end
        win_cnt = CNT_W'(end_w - (CNT_W+1)'(base_w));
        if (win_cnt == '0) begin
            win_cnt = CNT_W'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_in.opcode == OP_LOOKUP) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_v2 && r_last2) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            ST_IDLE:  ctrl = '0;
            ST_SCAN:  begin
                ctrl.busy  = 1'b1;
                ctrl.issue = 1'b1;
            end
            ST_DRAIN: ctrl.busy = 1'b1;
            default:  ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset  <= '0;
            r_total_colors <= CFG_W'(PALETTE_DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_OFFSET:  r_base_offset  <= i_cfg_data[7:0];
                CFG_TOTAL_COLORS: r_total_colors <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // palette write on load, one read per scan cycle
    always_ff @(posedge i_clk) begin
        if (accept && i_in.opcode == OP_LOAD && load_hit) begin
            r_palette[i_in.entry_index[IDX_W-1:0]] <= {i_in.red, i_in.green, i_in.blue};
        end
        if (ctrl.issue) begin
            r_rd_data <= r_palette[r_rd_addr];
        end
    end

    // query capture and read address walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_first_pend <= 1'b0;
        end else if (accept && i_in.opcode == OP_LOOKUP) begin
            r_left       <= win_cnt;
            r_first_pend <= 1'b1;
        end else if (ctrl.issue) begin
            r_left       <= r_left - CNT_W'(1);
            r_first_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.opcode == OP_LOOKUP) begin
            r_q_red   <= i_in.red & CHANNEL_MASK;
            r_q_green <= i_in.green & CHANNEL_MASK;
            r_q_blue  <= i_in.blue & CHANNEL_MASK;
            r_rd_addr <= base_w[IDX_W-1:0];
        end else if (ctrl.issue) begin
            r_rd_addr <= r_rd_addr + IDX_W'(1);
        end
    end

    // stage 1 tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= ctrl.issue;
        end
        r_first1 <= r_first_pend;
        r_last1  <= (r_left == CNT_W'(1));
        r_idx1   <= r_rd_addr;
    end

    // absolute channel differences on masked values
    always_comb begin
        logic [CH_W-1:0] p_r, p_g, p_b;
        p_r = r_rd_data[3*CH_W-1:2*CH_W] & CHANNEL_MASK;
        p_g = r_rd_data[2*CH_W-1:CH_W] & CHANNEL_MASK;
        p_b = r_rd_data[CH_W-1:0] & CHANNEL_MASK;
        d_r = (r_q_red > p_r) ? (r_q_red - p_r) : (p_r - r_q_red);
        d_g = (r_q_green > p_g) ? (r_q_green - p_g) : (p_g - r_q_green);
        d_b = (r_q_blue > p_b) ? (r_q_blue - p_b) : (p_b - r_q_blue);
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_idx2   <= r_idx1;
        r_sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g   <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);
    end

    // weighted sum 6g + 3r + b and compare against the running best
    always_comb begin
        cand_dist = (DIST_W'(r_sq_g) << 2) + (DIST_W'(r_sq_g) << 1)
                  + (DIST_W'(r_sq_r) << 1) + DIST_W'(r_sq_r)
                  + DIST_W'(r_sq_b);
        take      = r_first2 || (cand_dist < r_best_dist);
        sel_idx   = take ? r_idx2 : r_best_idx;
        sel_dist  = take ? cand_dist : r_best_dist;
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_best_idx  <= sel_idx;
            r_best_dist <= sel_dist;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_v2 && r_last2;
        end
        if (r_v2 && r_last2) begin
            r_out.best_index    <= 8'(sel_idx);
            r_out.best_distance <= sel_dist;
        end
    end

    assign busy    = ctrl.busy;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// File: tb/sv/nearest_palette_color_search_test.sv
`timescale 1ns / 100ps
// testbench: directed table and random phases checking the nearest palette color search
module nearest_palette_color_search_test;
    import npcs_pkg::*;

    localparam int ITEM_TARGET  = 760;
    localparam int MAX_PRINTS   = 20;
    localparam int GREEN_WEIGHT = 6;
    localparam int RED_WEIGHT   = 3;

    // register indexes past the two real registers, expected to be ignored
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam logic [DIST_W-1:0] FAR_DISTANCE = 20'd645160;

    // one row of the directed table: a register write or a command transfer
    typedef struct {
        bit               is_cfg;
        logic [1:0]       cfg_index;
        logic [CFG_W-1:0] cfg_value;
        t_in_item         item;
        bit               typed;
        t_out_item        want;
    } t_step;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_in_item         i_in        = '0;
    logic             i_cfg_we    = 1'b0;
    logic [1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             o_valid;
    t_out_item        o_out;

    // shadow copy of the palette and the search window
    logic [CH_W-1:0]  pal_red   [PALETTE_DEPTH];
    logic [CH_W-1:0]  pal_green [PALETTE_DEPTH];
    logic [CH_W-1:0]  pal_blue  [PALETTE_DEPTH];
    logic [7:0]       win_base  = '0;
    logic [CFG_W-1:0] win_count = 9'd256;

    t_out_item expected_nearest [$];
    t_step     directed [$];
    t_out_item due_result;
    int        mismatch_count = 0;
    int        burst_left     = 0;
    bit        idle_on        = 1'b1;

    nearest_palette_color_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("nearest_palette_color_search: mismatch");
        $finish;
    end

    task automatic flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("error at %0t: %s", $time, what);
        end
    endtask

    // squared difference of one channel with the low bit dropped
    function automatic int unsigned chan_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        int unsigned x;
        int unsigned y;
        x = a & CHANNEL_MASK;
        y = b & CHANNEL_MASK;
        return (x > y) ? (x - y) * (x - y) : (y - x) * (y - x);
    endfunction

    function automatic int unsigned color_dist(t_in_item q, int unsigned k);
        return GREEN_WEIGHT * chan_sq(q.green, pal_green[k])
             + RED_WEIGHT * chan_sq(q.red, pal_red[k])
             + chan_sq(q.blue, pal_blue[k]);
    endfunction

    // one past the last entry of the window, clipped at the palette end
    function automatic int unsigned window_end();
        int unsigned hi;
        hi = win_base + win_count;
        return (hi > PALETTE_DEPTH) ? PALETTE_DEPTH : hi;
    endfunction

    // nearest entry in the window, lowest index on ties
    function automatic t_out_item nearest_entry(t_in_item q);
        int unsigned hi;
        int unsigned k;
        int unsigned d;
        int unsigned best_d;
        int unsigned best_i;
        t_out_item   res;
        hi     = window_end();
        best_i = win_base;
        best_d = color_dist(q, win_base);
        for (k = win_base + 1; k < hi; k++) begin
            d = color_dist(q, k);
            if (d < best_d) begin
                best_d = d;
                best_i = k;
            end
        end
        res.best_index    = best_i[7:0];
        res.best_distance = best_d[DIST_W-1:0];
        return res;
    endfunction

    function automatic t_step item_step(t_opcode op, logic [7:0] slot, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b);
        t_step s;
        s.is_cfg           = 1'b0;
        s.cfg_index        = '0;
        s.cfg_value        = '0;
        s.item.opcode      = op;
        s.item.entry_index = slot;
        s.item.red         = r;
        s.item.green       = g;
        s.item.blue        = b;
        s.typed            = 1'b0;
        s.want             = '0;
        return s;
    endfunction

    function automatic t_step checked_step(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] idx, logic [DIST_W-1:0] want_dist);
        t_step s;
        s                    = item_step(OP_LOOKUP, 8'hff, r, g, b);
        s.typed              = 1'b1;
        s.want.best_index    = idx;
        s.want.best_distance = want_dist;
        return s;
    endfunction

    function automatic t_step reg_step(logic [1:0] idx, logic [CFG_W-1:0] val);
        t_step s;
        s           = item_step(OP_LOAD, '0, '0, '0, '0);
        s.is_cfg    = 1'b1;
        s.cfg_index = idx;
        s.cfg_value = val;
        return s;
    endfunction

    // random command: loads now and then, lookups near a window entry half the time
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned k;
        int unsigned hi;
        it.entry_index = 8'($urandom);
        it.red         = CH_W'($urandom);
        it.green       = CH_W'($urandom);
        it.blue        = CH_W'($urandom);
        if ($urandom_range(3, 0) == 0) begin
            it.opcode = OP_LOAD;
            // duplicate another entry's color so that ties come up
            if ($urandom_range(2, 0) == 0) begin
                k        = $urandom_range(PALETTE_DEPTH - 1, 0);
                it.red   = pal_red[k];
                it.green = pal_green[k];
                it.blue  = pal_blue[k];
            end
        end else begin
            it.opcode = OP_LOOKUP;
            if ($urandom_range(1, 0) != 0) begin
                hi       = window_end();
                k        = (hi > win_base + 1) ? $urandom_range(hi - 1, win_base) : win_base;
                it.red   = pal_red[k] ^ CH_W'($urandom_range(1, 0));
                it.green = pal_green[k] ^ CH_W'($urandom_range(1, 0));
                it.blue  = pal_blue[k] ^ CH_W'($urandom_range(1, 0));
            end
        end
        return it;
    endfunction

    // command transfer in bursts with random gaps, then update the shadow state
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        int gap;
        if (burst_left == 0) begin
            gap = idle_on ? $urandom_range(6, 0) : 0;
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(8, 1);
        end
        burst_left--;
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy);
        if (it.opcode == OP_LOAD) begin
            pal_red[it.entry_index]   = it.red;
            pal_green[it.entry_index] = it.green;
            pal_blue[it.entry_index]  = it.blue;
        end else begin
            expected_nearest.push_back(typed ? want : nearest_entry(it));
        end
    endtask

    // wait for every result and for the block to go idle
    task automatic settle();
        start <= 1'b0;
        while (expected_nearest.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_BASE_OFFSET) begin
            win_base = val[7:0];
        end else if (idx == CFG_TOTAL_COLORS) begin
            win_count = val;
        end
    endtask

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_nearest.size() == 0) begin
                flag_mismatch($sformatf("unexpected result index %0d distance %0d",
                                        o_out.best_index, o_out.best_distance));
            end else begin
                due_result = expected_nearest.pop_front();
                if (o_out.best_index !== due_result.best_index) begin
                    flag_mismatch($sformatf("best_index %0d, want %0d",
                                            o_out.best_index, due_result.best_index));
                end
                if (o_out.best_distance !== due_result.best_distance) begin
                    flag_mismatch($sformatf("best_distance %0d, want %0d",
                                            o_out.best_distance, due_result.best_distance));
                end
            end
        end
    end

    // stimulus
    initial begin
        int unsigned      n;
        int               sent;
        int               phase_len;
        t_step            s;
        t_in_item         fill;
        logic [7:0]       nb;
        logic [CFG_W-1:0] nc;

        // directed table, run over a palette where entry k is gray level k
        // reset window covers the whole palette; ties go to the lower index
        directed.push_back(checked_step(8'd0, 8'd0, 8'd0, 8'd0, '0));
        directed.push_back(checked_step(8'd255, 8'd255, 8'd255, 8'd254, '0));
        directed.push_back(checked_step(8'd1, 8'd1, 8'd1, 8'd0, '0));
        directed.push_back(item_step(OP_LOOKUP, 8'd0, 8'd0, 8'd255, 8'd0));
        directed.push_back(item_step(OP_LOAD, 8'd0, 8'd255, 8'd255, 8'd255));
        directed.push_back(item_step(OP_LOAD, 8'd255, 8'd0, 8'd0, 8'd0));
        directed.push_back(checked_step(8'd0, 8'd0, 8'd0, 8'd1, '0));
        // one-entry window at the last slot, farthest distance
        directed.push_back(reg_step(CFG_BASE_OFFSET, 9'd255));
        directed.push_back(reg_step(CFG_TOTAL_COLORS, 9'd1));
        directed.push_back(checked_step(8'd255, 8'd255, 8'd255, 8'd255, FAR_DISTANCE));
        // empty window: only the base entry is compared
        directed.push_back(reg_step(CFG_BASE_OFFSET, 9'd0));
        directed.push_back(reg_step(CFG_TOTAL_COLORS, 9'd0));
        directed.push_back(checked_step(8'd0, 8'd0, 8'd0, 8'd0, FAR_DISTANCE));
        // window running past the palette end
        directed.push_back(reg_step(CFG_BASE_OFFSET, 9'd200));
        directed.push_back(reg_step(CFG_TOTAL_COLORS, 9'd256));
        directed.push_back(checked_step(8'd201, 8'd201, 8'd201, 8'd200, '0));
        directed.push_back(item_step(OP_LOOKUP, 8'd17, 8'd0, 8'd0, 8'd0));
        // writes to unused indexes leave the window alone
        directed.push_back(reg_step(CFG_SPARE_A, 9'h1ff));
        directed.push_back(reg_step(CFG_SPARE_B, 9'h000));
        directed.push_back(item_step(OP_LOOKUP, 8'd90, 8'd10, 8'd20, 8'd30));
        // weighting across channels
        directed.push_back(reg_step(CFG_BASE_OFFSET, 9'd0));
        directed.push_back(reg_step(CFG_TOTAL_COLORS, 9'd256));
        directed.push_back(item_step(OP_LOAD, 8'd128, 8'd130, 8'd0, 8'd0));
        directed.push_back(item_step(OP_LOOKUP, 8'd128, 8'd128, 8'd128, 8'd0));
        directed.push_back(item_step(OP_LOOKUP, 8'd3, 8'd0, 8'd90, 8'd255));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole palette so that no lookup reads an unwritten entry
        for (n = 0; n < PALETTE_DEPTH; n++) begin
            fill.opcode      = OP_LOAD;
            fill.entry_index = n[7:0];
            fill.red         = n[7:0];
            fill.green       = n[7:0];
            fill.blue        = n[7:0];
            send_item(fill, 1'b0, '0);
        end

        for (n = 0; n < directed.size(); n++) begin
            s = directed[n];
            if (s.is_cfg) begin
                settle();
                write_reg(s.cfg_index, s.cfg_value);
                i_cfg_we <= 1'b0;
            end else begin
                send_item(s.item, s.typed, s.want);
            end
        end

        // random phases, each with its own window and idle pattern
        sent = 0;
        while (sent < ITEM_TARGET) begin
            case ($urandom_range(9, 0))
                0:       nb = 8'd0;
                1:       nb = 8'd255;
                default: nb = 8'($urandom);
            endcase
            case ($urandom_range(9, 0))
                0:       nc = '0;
                1:       nc = 9'd1;
                2:       nc = 9'd256;
                3, 4:    nc = CFG_W'($urandom_range(256, 1));
                default: nc = CFG_W'($urandom_range(16, 2));
            endcase
            settle();
            if ($urandom_range(3, 0) == 0) begin
                write_reg(($urandom_range(1, 0) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_W'($urandom));
            end
            if ($urandom_range(1, 0) != 0) begin
                write_reg(CFG_BASE_OFFSET, {1'b0, nb});
                write_reg(CFG_TOTAL_COLORS, nc);
            end else begin
                write_reg(CFG_TOTAL_COLORS, nc);
                write_reg(CFG_BASE_OFFSET, {1'b0, nb});
            end
            i_cfg_we <= 1'b0;
            idle_on   = ($urandom_range(3, 0) != 0);
            phase_len = $urandom_range(50, 10);
            repeat (phase_len) begin
                send_item(random_item(), 1'b0, '0);
                sent++;
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("nearest_palette_color_search: match");
        end else begin
            $display("nearest_palette_color_search: mismatch");
        end
        $finish;
    end

endmodule
